// ----- hw/rtl/pfa_pkg.sv -----
package pfa_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int CFG_W     = 5;
  localparam int FUNC_W    = 3;
  localparam int ENTRY_W   = 4;
  localparam int REQ_W     = 16;
  localparam int OWNER_W   = 8;
  localparam int POS_W     = 4;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIRST = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_BEST  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_NEXT  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WORST = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [ENTRY_W-1:0] entry_index;
    logic [REQ_W-1:0]   request_size;
    logic [OWNER_W-1:0] owner_tag;
  } pfa_in_t;

  typedef struct packed {
    logic             granted;
    logic [POS_W-1:0] position;
  } pfa_out_t;

  typedef struct packed {
    logic rd_en;
    logic ld_en;
    logic gr_en;
  } tbl_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_COMMIT,
    ST_DONE
  } pfa_state_t;

endpackage

// ----- hw/rtl/pfa_table.sv -----
module pfa_table #(
  parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W          = $clog2(MAX_PARTITIONS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  pfa_pkg::tbl_cmd_t          cmd,
  input  logic [IDX_W-1:0]           idx,
  input  logic [SIZE_BITS-1:0]       wr_size,
  input  logic [pfa_pkg::OWNER_W-1:0] wr_owner,
  output logic [SIZE_BITS-1:0]       rd_size,
  output logic                       rd_taken
);
  import pfa_pkg::*;

  logic [SIZE_BITS-1:0] size_mem_r  [MAX_PARTITIONS];
  logic [OWNER_W-1:0]   owner_mem_r [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] vld_r;
  logic [MAX_PARTITIONS-1:0] taken_r;
  logic [SIZE_BITS-1:0] rd_size_r;
  logic                 rd_vld_r;
  logic                 rd_taken_r;

  // sizes and owners live in memory, read data registered
  always_ff @(posedge clk) begin
    if (cmd.ld_en) begin
      size_mem_r[idx] <= wr_size;
    end
    if (cmd.gr_en) begin
      owner_mem_r[idx] <= wr_owner;
    end
    if (cmd.rd_en) begin
      rd_size_r <= size_mem_r[idx];
    end
  end

  // entry valid and taken flags, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      taken_r    <= '0;
      rd_vld_r   <= 1'b0;
      rd_taken_r <= 1'b0;
    end else begin
      if (cmd.ld_en) begin
        vld_r[idx]   <= 1'b1;
        taken_r[idx] <= 1'b0;
      end else if (cmd.gr_en) begin
        taken_r[idx] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_vld_r   <= vld_r[idx];
        rd_taken_r <= taken_r[idx];
      end
    end
  end

  // an entry never loaded reads as size zero
  assign rd_size  = rd_vld_r ? rd_size_r : '0;
  assign rd_taken = rd_taken_r;

endmodule

// ----- hw/rtl/pfa_seq.sv -----
module pfa_seq #(
  parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF,
  parameter int IDX_W          = $clog2(MAX_PARTITIONS),
  parameter int CNT_W          = IDX_W + 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  pfa_pkg::pfa_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output pfa_pkg::pfa_out_t           out_data,
  input  logic [CNT_W-1:0]            part_cnt,
  output pfa_pkg::tbl_cmd_t           tbl_cmd,
  output logic [IDX_W-1:0]            tbl_idx,
  output logic [SIZE_BITS-1:0]        tbl_wr_size,
  output logic [pfa_pkg::OWNER_W-1:0] tbl_wr_owner,
  input  logic [SIZE_BITS-1:0]        tbl_rd_size,
  input  logic                        tbl_rd_taken
);
  import pfa_pkg::*;

  localparam int CW = (SIZE_BITS > REQ_W) ? SIZE_BITS : REQ_W;

  pfa_state_t state_r, state_nxt;
  pfa_in_t    item_r, item_nxt;
  logic [CNT_W-1:0]     rd_cnt_r, rd_cnt_nxt;
  logic [IDX_W-1:0]     rd_idx_r, rd_idx_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     pick_r, pick_nxt;
  logic [SIZE_BITS-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]     next_start_r, next_start_nxt;
  pfa_out_t             res_r, res_nxt;
  logic                 out_valid_r, out_valid_nxt;
  pfa_out_t             out_data_r, out_data_nxt;

  logic             accept;
  logic             issue;
  logic             scan_end;
  logic             load_ok;
  logic             fits;
  logic             better;
  logic             take;
  logic             out_free;
  logic [CNT_W-1:0] rd_idx_inc;
  logic [CNT_W-1:0] pick_inc;
  logic [IDX_W-1:0] start_idx;

  assign accept   = in_valid && !in_stall;
  assign issue    = (state_r == ST_SCAN) && (rd_cnt_r != part_cnt);
  assign scan_end = (state_r == ST_SCAN) && (rd_cnt_r == part_cnt) && !ev_vld_r;
  assign load_ok  = 32'(item_r.entry_index) < 32'(MAX_PARTITIONS);
  assign out_free = !out_valid_r || !out_stall;

  assign rd_idx_inc = CNT_W'(rd_idx_r) + CNT_W'(1);
  assign pick_inc   = CNT_W'(pick_r) + CNT_W'(1);
  assign start_idx  = ((in_data.func == FUNC_NEXT) && (next_start_r < part_cnt)) ?
                      IDX_W'(next_start_r) : '0;

  // shared compare unit, one table entry per cycle
  assign fits   = ev_vld_r && !tbl_rd_taken &&
                  (CW'(tbl_rd_size) >= CW'(item_r.request_size));
  assign better = (item_r.func == FUNC_BEST) ? (tbl_rd_size < best_r) :
                                              (tbl_rd_size > best_r);
  assign take   = fits && (!found_r ||
                  (((item_r.func == FUNC_BEST) || (item_r.func == FUNC_WORST)) && better));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.func == FUNC_LOAD) begin
            state_nxt = ST_LOAD;
          end else if ((in_data.func == FUNC_FIRST) || (in_data.func == FUNC_BEST) ||
                       (in_data.func == FUNC_NEXT) || (in_data.func == FUNC_WORST)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LOAD:   state_nxt = ST_DONE;
      ST_SCAN: begin
        if (scan_end) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs toward the table and the input channel
  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    tbl_cmd      = '0;
    tbl_idx      = rd_idx_r;
    tbl_wr_size  = SIZE_BITS'(item_r.request_size);
    tbl_wr_owner = item_r.owner_tag;
    case (state_r)
      ST_SCAN: begin
        tbl_cmd.rd_en = issue;
        tbl_idx       = rd_idx_r;
      end
      ST_LOAD: begin
        tbl_cmd.ld_en = load_ok;
        tbl_idx       = IDX_W'(item_r.entry_index);
      end
      ST_COMMIT: begin
        tbl_cmd.gr_en = found_r;
        tbl_idx       = pick_r;
      end
      default: begin
        tbl_cmd = '0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    item_nxt       = item_r;
    rd_cnt_nxt     = rd_cnt_r;
    rd_idx_nxt     = rd_idx_r;
    ev_vld_nxt     = issue;
    ev_idx_nxt     = rd_idx_r;
    found_nxt      = found_r;
    pick_nxt       = pick_r;
    best_nxt       = best_r;
    next_start_nxt = next_start_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    if (accept) begin
      item_nxt   = in_data;
      rd_cnt_nxt = '0;
      rd_idx_nxt = start_idx;
      found_nxt  = 1'b0;
      pick_nxt   = '0;
      res_nxt    = '0;
    end

    if (issue) begin
      rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
      rd_idx_nxt = (rd_idx_inc == part_cnt) ? '0 : IDX_W'(rd_idx_inc);
    end

    if (take) begin
      found_nxt = 1'b1;
      pick_nxt  = ev_idx_r;
      best_nxt  = tbl_rd_size;
    end

    if (state_r == ST_LOAD) begin
      res_nxt.granted  = load_ok;
      res_nxt.position = load_ok ? item_r.entry_index : '0;
    end

    if (state_r == ST_COMMIT) begin
      res_nxt.granted  = found_r;
      res_nxt.position = found_r ? POS_W'(pick_r) : '0;
      if (found_r && (item_r.func == FUNC_NEXT)) begin
        next_start_nxt = (pick_inc >= part_cnt) ? '0 : pick_inc;
      end
    end

    if ((state_r == ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_cnt_r     <= '0;
      ev_vld_r     <= 1'b0;
      found_r      <= 1'b0;
      next_start_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      rd_cnt_r     <= rd_cnt_nxt;
      ev_vld_r     <= ev_vld_nxt;
      found_r      <= found_nxt;
      next_start_r <= next_start_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    rd_idx_r   <= rd_idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    pick_r     <= pick_nxt;
    best_r     <= best_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/partition_fit_allocator_unit.sv -----
// Fixed-partition allocator: a table of partitions with size, taken flag and owner.
// Input channel (in_valid / in_stall / in_data) carries one operation per transfer:
// load a partition size, or request a size under first, best, next or worst fit.
// Result channel (out_valid / out_stall / out_data) returns granted and position,
// exactly one result per input transfer, in order.
// cfg_wr_en / cfg_wr_data set the number of partitions searched (reset 16); the user
// must write them only while the block is idle, as the block itself does not enforce it.
// A search reads one table entry per cycle from the size memory through one
// compare unit, then commits the grant and registers the result. A load writes
// the table entry and registers its result; an unknown operation goes straight
// to its result with granted low. One item is worked on at a time; in_stall is
// high meanwhile.
// The result sits in an output register, so the next item is taken while it waits;
// if out_stall holds it, a following result waits in the sequencer until it drains.
// Synchronous reset (rst_n low) frees every partition with size zero,
// resets the next-fit pointer and drops any pending result. No clearing pass.
module partition_fit_allocator_unit #(
  parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  pfa_pkg::pfa_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output pfa_pkg::pfa_out_t         out_data,
  input  logic                      cfg_wr_en,
  input  logic [pfa_pkg::CFG_W-1:0] cfg_wr_data
);
  import pfa_pkg::*;

  localparam int IDX_W = $clog2(MAX_PARTITIONS);
  localparam int CNT_W = IDX_W + 1;
  localparam int SAT_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  logic [CFG_W-1:0]     cfg_r;
  logic [CNT_W-1:0]     part_cnt;
  tbl_cmd_t             tbl_cmd;
  logic [IDX_W-1:0]     tbl_idx;
  logic [SIZE_BITS-1:0] tbl_wr_size;
  logic [OWNER_W-1:0]   tbl_wr_owner;
  logic [SIZE_BITS-1:0] tbl_rd_size;
  logic                 tbl_rd_taken;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // partitions in use saturate at the table depth
  assign part_cnt = (SAT_W'(cfg_r) > SAT_W'(MAX_PARTITIONS)) ?
                    CNT_W'(MAX_PARTITIONS) : CNT_W'(cfg_r);

  pfa_seq #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS),
    .IDX_W          (IDX_W),
    .CNT_W          (CNT_W)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .part_cnt     (part_cnt),
    .tbl_cmd      (tbl_cmd),
    .tbl_idx      (tbl_idx),
    .tbl_wr_size  (tbl_wr_size),
    .tbl_wr_owner (tbl_wr_owner),
    .tbl_rd_size  (tbl_rd_size),
    .tbl_rd_taken (tbl_rd_taken)
  );

  pfa_table #(
    .MAX_PARTITIONS (MAX_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS),
    .IDX_W          (IDX_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (tbl_cmd),
    .idx      (tbl_idx),
    .wr_size  (tbl_wr_size),
    .wr_owner (tbl_wr_owner),
    .rd_size  (tbl_rd_size),
    .rd_taken (tbl_rd_taken)
  );

endmodule
